>>> rtl/core/tpe_pkg.sv
package tpe_pkg;

  localparam int DIST_FRAC_BITS   = 24;
  localparam int ENERGY_FRAC_BITS = 24;

  localparam int R_W    = 32;               // r_squared
  localparam int E_W    = 40;               // energy and shifts
  localparam int ST_W   = 2;
  localparam int KIND_W = 2;

  // 1/r2 in Q.32: r2 >= 2^-6 keeps it at or below 2^38
  localparam int Q_W    = 39;
  localparam int REM_W  = R_W + 1;
  // sqrt operand is r2 in Q.32
  localparam int X_W    = 64 - DIST_FRAC_BITS;
  localparam int SQ_W   = (X_W + 1) / 2;
  localparam int SR_W   = SQ_W + 4;

  localparam int MH_W   = 24;               // partial product half width
  localparam int M_W    = 2 * MH_W;
  localparam int P_W    = 2 * M_W;
  localparam int S6_W   = 45;               // s6 below 2^45 or saturated
  localparam int SUM_W  = 64;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [KIND_W-1:0] KIND_LJ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SW = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_CORE = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

  localparam logic [2:0] REG_KIND   = 3'd0;
  localparam logic [2:0] REG_CUT_EN = 3'd1;
  localparam logic [2:0] REG_CUT_SQ = 3'd2;
  localparam logic [2:0] REG_E_SH   = 3'd3;
  localparam logic [2:0] REG_F_SH   = 3'd4;

  typedef enum logic [2:0] {
    CLS_CALC,
    CLS_ZERO,
    CLS_SAT,
    CLS_SWOUT,
    CLS_CORE
  } cls_t;

  typedef struct packed {
    cls_t           cls;
    logic           ss;
    logic [R_W-1:0] r;
  } item_t;

  typedef struct packed {
    logic vld;
    cls_t cls;
    logic ss;
  } tag_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic                  cut_en;
    logic [R_W-1:0]        cut_sq;
    logic signed [E_W-1:0] e_shift;
    logic signed [E_W-1:0] f_shift;
  } cfg_t;

endpackage

>>> rtl/core/truncated_pair_potential_energy_top.sv
// Pair energy unit: one squared distance in, one energy with status out.
// Path from input transfer to result valid: 4-entry queue, 39-stage divide/sqrt
// pipe, three 2-stage multipliers in series, t, term and output registers.
// Throughput: one pair per cycle, set by the fully pipelined back end; stalls only
// when the result is not taken. Reset (rst_n low, synchronous) empties the queue
// and pipe and loads the register defaults.
module truncated_pair_potential_energy_top import tpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // [31:0] r_squared
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,   // [39:0] energy
  output logic [1:0]        out_tuser,   // [1:0] status
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // registers, 8-byte stride
  logic [KIND_W-1:0]     kind_r;
  logic                  cut_en_r;
  logic [R_W-1:0]        cut_sq_r;
  logic signed [E_W-1:0] e_shift_r;
  logic signed [E_W-1:0] f_shift_r;
  logic                  wr_en;
  cfg_t                  cfg;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_LJ;
      cut_en_r  <= 1'b1;
      cut_sq_r  <= '0;
      e_shift_r <= '0;
      f_shift_r <= '0;
    end else if (wr_en) begin
      case (cfg_paddr[5:3])
        REG_KIND:   kind_r    <= cfg_pwdata[KIND_W-1:0];
        REG_CUT_EN: cut_en_r  <= cfg_pwdata[0];
        REG_CUT_SQ: cut_sq_r  <= cfg_pwdata[R_W-1:0];
        REG_E_SH:   e_shift_r <= cfg_pwdata[E_W-1:0];
        REG_F_SH:   f_shift_r <= cfg_pwdata[E_W-1:0];
        default:    kind_r    <= kind_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      REG_KIND:   cfg_prdata = DATA_W'(kind_r);
      REG_CUT_EN: cfg_prdata = DATA_W'(cut_en_r);
      REG_CUT_SQ: cfg_prdata = DATA_W'(cut_sq_r);
      REG_E_SH:   cfg_prdata = DATA_W'(e_shift_r);
      REG_F_SH:   cfg_prdata = DATA_W'(f_shift_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg = '{kind: kind_r, cut_en: cut_en_r, cut_sq: cut_sq_r,
                 e_shift: e_shift_r, f_shift: f_shift_r};

  // front: classify and queue
  logic  q_vld, q_pop;
  item_t q_item;

  tpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_r      (in_tdata),
    .cfg       (cfg),
    .q_pop     (q_pop),
    .q_vld     (q_vld),
    .q_item    (q_item)
  );

  // back: arithmetic pipe and output register
  logic signed [E_W-1:0] energy;
  logic [ST_W-1:0]       status;

  tpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_energy (energy),
    .out_status (status)
  );

  assign out_tdata = energy;
  assign out_tuser = status;

endmodule

>>> rtl/core/tpe_front.sv
module tpe_front import tpe_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [R_W-1:0] in_r,
  input  cfg_t           cfg,
  input  logic           q_pop,
  output logic           q_vld,
  output item_t          q_item
);

  localparam int QD   = 4;
  localparam int QA_W = 2;

  item_t             mem_r [QD];
  logic [QA_W:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QA_W:0]     rd_ptr_r, rd_ptr_nxt;
  logic              full, empty, push;
  item_t             item;

  assign full      = (wr_ptr_r ^ rd_ptr_r) == {1'b1, {QA_W{1'b0}}};
  assign empty     = wr_ptr_r == rd_ptr_r;
  assign in_tready = !full;
  assign push      = in_tvalid && !full;
  assign q_vld     = !empty;
  assign q_item    = mem_r[rd_ptr_r[QA_W-1:0]];

  // classify the pair before it enters the arithmetic
  always_comb begin
    item.r  = in_r;
    item.ss = cfg.kind == KIND_SS;
    if (cfg.cut_en && (in_r > cfg.cut_sq)) begin
      item.cls = CLS_ZERO;
    end else if (cfg.kind == KIND_SW) begin
      item.cls = ({1'b0, in_r} > (33'(1) << DIST_FRAC_BITS)) ? CLS_SWOUT : CLS_CORE;
    end else if (in_r < (R_W'(1) << (DIST_FRAC_BITS - 6))) begin
      item.cls = CLS_SAT;
    end else begin
      item.cls = CLS_CALC;
    end
  end

  assign wr_ptr_nxt = wr_ptr_r + (QA_W+1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (QA_W+1)'(q_pop && !empty);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[QA_W-1:0]] <= item;
    end
  end

endmodule

>>> rtl/core/tpe_root.sv
module tpe_root import tpe_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  tag_t            in_tag,
  input  logic [R_W-1:0]  in_r,
  output tag_t            out_tag,
  output logic [Q_W-1:0]  out_inv,
  output logic [SQ_W-1:0] out_sq
);

  localparam int XP_W = 2 * SQ_W;

  tag_t             tag_r  [Q_W];
  logic [R_W-1:0]   r_r    [Q_W];
  logic [REM_W-1:0] rem_r  [Q_W];
  logic [Q_W-1:0]   q_r    [Q_W];
  logic [SR_W-1:0]  srem_r [Q_W];
  logic [SQ_W-1:0]  root_r [Q_W];
  logic [REM_W-1:0] rem_init;

  // leading quotient bits of 2^(DFB+32)/r are zero, the partial remainder starts here
  assign rem_init = REM_W'(1) << (DIST_FRAC_BITS - 7);

  genvar k;
  for (k = 0; k < Q_W; k++) begin : g_stage
    tag_t             tag_p;
    logic [R_W-1:0]   r_p;
    logic [REM_W-1:0] rem_p, rem_s, rem_n;
    logic [Q_W-1:0]   q_p;
    logic [SR_W-1:0]  srem_p, srem_n;
    logic [SQ_W-1:0]  root_p, root_n;
    logic             ge;

    if (k == 0) begin : g_first
      assign tag_p  = in_tag;
      assign r_p    = in_r;
      assign rem_p  = rem_init;
      assign q_p    = '0;
      assign srem_p = '0;
      assign root_p = '0;
    end else begin : g_next
      assign tag_p  = tag_r[k-1];
      assign r_p    = r_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign q_p    = q_r[k-1];
      assign srem_p = srem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // one restoring division step
    assign rem_s = {rem_p[REM_W-2:0], 1'b0};
    assign ge    = rem_s >= {1'b0, r_p};
    assign rem_n = ge ? (rem_s - {1'b0, r_p}) : rem_s;

    // one square root digit in the first SQ_W stages
    if (k < SQ_W) begin : g_sq
      localparam int PI = SQ_W - 1 - k;
      logic [XP_W-1:0] xp;
      logic [SR_W-1:0] srs, trial;
      logic            sge;
      assign xp     = XP_W'(64'(r_p) << (32 - DIST_FRAC_BITS));
      assign srs    = {srem_p[SR_W-3:0], xp[2*PI+1 -: 2]};
      assign trial  = SR_W'({root_p, 2'b01});
      assign sge    = srs >= trial;
      assign srem_n = sge ? (srs - trial) : srs;
      assign root_n = {root_p[SQ_W-2:0], sge};
    end else begin : g_sq_hold
      assign srem_n = srem_p;
      assign root_n = root_p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= r_p;
        rem_r[k]  <= rem_n;
        q_r[k]    <= {q_p[Q_W-2:0], ge};
        srem_r[k] <= srem_n;
        root_r[k] <= root_n;
      end
    end
  end

  assign out_tag = tag_r[Q_W-1];
  assign out_inv = q_r[Q_W-1];
  assign out_sq  = root_r[Q_W-1];

endmodule

>>> rtl/core/tpe_mul.sv
module tpe_mul import tpe_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [M_W-1:0] a,
  input  logic [M_W-1:0] b,
  output logic [P_W-1:0] p
);

  // four 24x24 partial products, then one registered sum
  logic [M_W-1:0] pp_r [4];
  logic [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= a[MH_W-1:0]   * b[MH_W-1:0];
      pp_r[1] <= a[M_W-1:MH_W] * b[MH_W-1:0];
      pp_r[2] <= a[MH_W-1:0]   * b[M_W-1:MH_W];
      pp_r[3] <= a[M_W-1:MH_W] * b[M_W-1:MH_W];
      p_r     <= P_W'(pp_r[0])
               + (P_W'(pp_r[1]) << MH_W)
               + (P_W'(pp_r[2]) << MH_W)
               + (P_W'(pp_r[3]) << M_W);
    end
  end

  assign p = p_r;

endmodule

>>> rtl/core/tpe_back.sv
module tpe_back import tpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  item_t                 q_item,
  output logic                  q_pop,
  input  cfg_t                  cfg,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic signed [E_W-1:0] out_energy,
  output logic [ST_W-1:0]       out_status
);

  localparam logic signed [SUM_W-1:0] SUM_EMAX = (SUM_W'(1) << (E_W-1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_EMIN = -(SUM_W'(1) << (E_W-1));
  localparam logic [E_W-1:0]          E_MAX    = {1'b0, {(E_W-1){1'b1}}};
  localparam logic [E_W-1:0]          E_MIN    = {1'b1, {(E_W-1){1'b0}}};
  localparam logic [E_W-1:0]          E_NEG1   = -(E_W'(1) << ENERGY_FRAC_BITS);
  localparam logic [S6_W-1:0]         S6_ONE   = S6_W'(1) << 32;

  logic                  en;
  logic                  out_vld_r;
  logic signed [E_W-1:0] energy_r, energy_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;

  assign en    = !out_vld_r || out_tready;
  assign q_pop = en && q_vld;

  // divide and square root pipe
  tag_t            in_tag, a_tag;
  logic [Q_W-1:0]  a_inv;
  logic [SQ_W-1:0] a_sq;

  assign in_tag = '{vld: q_vld, cls: q_item.cls, ss: q_item.ss};

  tpe_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (in_tag),
    .in_r    (q_item.r),
    .out_tag (a_tag),
    .out_inv (a_inv),
    .out_sq  (a_sq)
  );

  // inv^2 and |force_shift|*sqrt(r2)
  logic           fneg;
  logic [E_W-1:0] fmag;
  logic [P_W-1:0] p1, p2, p3, p4;

  assign fneg = cfg.f_shift[E_W-1];
  assign fmag = fneg ? E_W'(-cfg.f_shift) : E_W'(cfg.f_shift);

  tpe_mul u_mul_sq (.clk(clk), .en(en), .a(M_W'(a_inv)), .b(M_W'(a_inv)), .p(p1));
  tpe_mul u_mul_f  (.clk(clk), .en(en), .a(M_W'(fmag)),  .b(M_W'(a_sq)),  .p(p4));

  tag_t           b_tag_r [2];
  logic [Q_W-1:0] b_inv_r [2];

  // s6 = inv2 * inv
  logic [S6_W-1:0] inv2;
  assign inv2 = p1[S6_W+31:32];

  tpe_mul u_mul_s6 (.clk(clk), .en(en), .a(M_W'(inv2)), .b(M_W'(b_inv_r[1])), .p(p2));

  tag_t             c_tag_r [2];
  logic [SUM_W-1:0] c_fm_r  [2];

  // form t
  logic [S6_W-1:0]  s6, tmag;
  logic             tneg, sat6;
  tag_t             t_tag_r;
  logic [S6_W-1:0]  t_s6_r, t_tmag_r;
  logic             t_tneg_r, t_sat_r;
  logic [SUM_W-1:0] t_fm_r;

  assign s6   = p2[S6_W+31:32];
  assign sat6 = |p2[P_W-1:S6_W+32];

  always_comb begin
    if (c_tag_r[1].ss) begin
      tmag = s6;
      tneg = 1'b0;
    end else if (s6 >= S6_ONE) begin
      tmag = s6 - S6_ONE;
      tneg = 1'b0;
    end else begin
      tmag = S6_ONE - s6;
      tneg = 1'b1;
    end
  end

  tpe_mul u_mul_lj (.clk(clk), .en(en), .a(M_W'(t_s6_r)), .b(M_W'(t_tmag_r)), .p(p3));

  tag_t             d_tag_r  [2];
  logic             d_tneg_r [2];
  logic             d_sat_r  [2];
  logic [SUM_W-1:0] d_fm_r   [2];

  // signed terms
  logic [P_W-31:0]         lm_w;
  logic [SUM_W-1:0]        lmag;
  tag_t                    s_tag_r;
  logic                    s_sat_r;
  logic signed [SUM_W-1:0] s_lj_r, s_ft_r;
  logic signed [SUM_W-1:0] sum;

  assign lm_w = {p3[P_W-1:32], 2'b00} >> (32 - ENERGY_FRAC_BITS);
  assign lmag = lm_w[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r[0] <= '0;
      b_tag_r[1] <= '0;
      c_tag_r[0] <= '0;
      c_tag_r[1] <= '0;
      t_tag_r    <= '0;
      d_tag_r[0] <= '0;
      d_tag_r[1] <= '0;
      s_tag_r    <= '0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      b_tag_r[0] <= a_tag;
      b_tag_r[1] <= b_tag_r[0];
      c_tag_r[0] <= b_tag_r[1];
      c_tag_r[1] <= c_tag_r[0];
      t_tag_r    <= c_tag_r[1];
      d_tag_r[0] <= t_tag_r;
      d_tag_r[1] <= d_tag_r[0];
      s_tag_r    <= d_tag_r[1];
      out_vld_r  <= s_tag_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inv_r[0]  <= a_inv;
      b_inv_r[1]  <= b_inv_r[0];
      c_fm_r[0]   <= p4[SUM_W+15:16];
      c_fm_r[1]   <= c_fm_r[0];
      t_s6_r      <= s6;
      t_tmag_r    <= tmag;
      t_tneg_r    <= tneg;
      t_sat_r     <= sat6;
      t_fm_r      <= c_fm_r[1];
      d_tneg_r[0] <= t_tneg_r;
      d_tneg_r[1] <= d_tneg_r[0];
      d_sat_r[0]  <= t_sat_r;
      d_sat_r[1]  <= d_sat_r[0];
      d_fm_r[0]   <= t_fm_r;
      d_fm_r[1]   <= d_fm_r[0];
      s_sat_r     <= d_sat_r[1];
      s_lj_r      <= d_tneg_r[1] ? -lmag : lmag;
      s_ft_r      <= fneg ? -d_fm_r[1] : d_fm_r[1];
      energy_r    <= energy_nxt;
      status_r    <= status_nxt;
    end
  end

  assign sum = s_lj_r + s_ft_r + {{(SUM_W-E_W){cfg.e_shift[E_W-1]}}, cfg.e_shift};

  always_comb begin
    energy_nxt = E_MAX;
    status_nxt = ST_OK;
    case (s_tag_r.cls)
      CLS_ZERO:  energy_nxt = '0;
      CLS_SWOUT: energy_nxt = E_NEG1;
      CLS_CORE:  status_nxt = ST_CORE;
      CLS_SAT:   status_nxt = ST_SAT;
      CLS_CALC: begin
        if (s_sat_r) begin
          status_nxt = ST_SAT;
        end else if (sum > SUM_EMAX) begin
          status_nxt = ST_SAT;
        end else if (sum < SUM_EMIN) begin
          energy_nxt = E_MIN;
          status_nxt = ST_SAT;
        end else begin
          energy_nxt = sum[E_W-1:0];
        end
      end
      default: energy_nxt = E_MAX;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_energy = energy_r;
  assign out_status = status_r;

endmodule
